### rtl/core/salsa_pkg.sv
// Shared types, constants and helper functions for the Salsa20 stream cipher core.
// No dependencies; salsa_ctrl, salsa_dp and the top level refer to it by scoped names.
package salsa_pkg;

   // Rounds of the core permutation; odd values run one more full double round.
   localparam int Rounds        = 20;
   localparam int DoubleRounds  = (Rounds + 1) / 2;
   localparam int RoundCntWidth = (DoubleRounds > 1) ? $clog2(DoubleRounds) : 1;

   localparam int WordCount = 16;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 64;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CsrKeyWord0 = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyWord1 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrKeyWord2 = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrKeyWord3 = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrNonce    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrKeyMode  = 3'd5;

   // Expansion constants: "expand 32-byte k" and "expand 16-byte k"
   localparam logic [31:0] ExpandWord0   = 32'h61707865;
   localparam logic [31:0] ExpandWord15  = 32'h6b206574;
   localparam logic [31:0] Sigma5        = 32'h3320646e;
   localparam logic [31:0] Sigma10       = 32'h79622d32;
   localparam logic [31:0] Tau5          = 32'h3120646e;
   localparam logic [31:0] Tau10         = 32'h79622d36;

   typedef logic [31:0] word_type;
   typedef word_type [WordCount-1:0] block_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;     // build the initial block, copy it to the work words
      logic       step;     // one quarter-round step on all four quarters
      logic       row;      // 0: column round, 1: row round
      logic [1:0] qstep;    // which of the four quarter-round lines
      logic       finish;   // add the initial block back in
      logic       take;     // accept a request byte and register its result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pos_zero;       // byte count sits on a 64-byte boundary
   } sts_type;

   // Word index of position pos (a, b, c, d) in quarter-round quarter.
   // Column: (5q + 4p) mod 16. Row: 4q + ((q + p) mod 4).
   function automatic logic [3:0] word_index(input logic row, input logic [1:0] quarter,
                                             input logic [1:0] pos);
      logic [3:0] col_idx;
      logic [1:0] lane;
      col_idx = ({2'b00, quarter} << 2) + {2'b00, quarter} + {pos, 2'b00};
      lane    = quarter + pos;
      return row ? {quarter, lane} : col_idx;
   endfunction

   // Rotate left by 7, 9, 13 or 18 for the four quarter-round lines
   function automatic word_type rotate_step(input word_type v, input logic [1:0] s);
      word_type r;
      unique case (s)
         2'd0:    r = {v[24:0], v[31:25]};
         2'd1:    r = {v[22:0], v[31:23]};
         2'd2:    r = {v[18:0], v[31:19]};
         default: r = {v[13:0], v[31:14]};
      endcase
      return r;
   endfunction

endpackage

### rtl/core/salsa_ctrl.sv
// Controller of the Salsa20 core: block generation sequence and request/response handshake.
// Depends on salsa_pkg.
module salsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  salsa_pkg::sts_type sts,
   output salsa_pkg::cmd_type cmd
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StRound  = 2'd1;
   localparam logic [1:0] StFinish = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [salsa_pkg::RoundCntWidth-1:0] dround_ff, dround_in;
   logic fresh_ff, fresh_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle) && (fresh_ff || !sts.pos_zero) && slot_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.row    = step_ff[2];
      cmd.qstep  = step_ff[1:0];
      cmd.take   = req_valid && req_ready;
      state_in   = state_ff;
      step_in    = step_ff;
      dround_in  = dround_ff;
      fresh_in   = fresh_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_valid && sts.pos_zero && !fresh_ff) begin
               cmd.load  = 1'b1;
               step_in   = '0;
               dround_in = '0;
               state_in  = StRound;
            end
         end
         StRound: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               if (dround_ff == salsa_pkg::RoundCntWidth'(salsa_pkg::DoubleRounds - 1)) begin
                  state_in = StFinish;
               end else begin
                  dround_in = dround_ff + salsa_pkg::RoundCntWidth'(1);
               end
            end
         end
         StFinish: begin
            cmd.finish = 1'b1;
            fresh_in   = 1'b1;
            state_in   = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      if (cmd.take) begin
         fresh_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         dround_ff    <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dround_ff    <= dround_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Requests are only taken while no block is being generated
   assert property (@(posedge clock) disable iff (reset) req_ready |-> state_ff == StIdle)
      else $error("request accepted during block generation");

   // A byte on a block boundary needs a freshly generated block
   assert property (@(posedge clock) disable iff (reset)
                    (cmd.take && sts.pos_zero) |-> fresh_ff)
      else $error("boundary byte taken without a new block");

   // A fresh block comes only out of the final add
   assert property (@(posedge clock) disable iff (reset)
                    $rose(fresh_ff) |-> $past(state_ff) == StFinish)
      else $error("block marked fresh outside the final add");

   // Generation starts only on a boundary with a request waiting
   assert property (@(posedge clock) disable iff (reset)
                    cmd.load |-> (sts.pos_zero && !fresh_ff && req_valid))
      else $error("block generation started off a boundary");

endmodule

### rtl/core/salsa_dp.sv
// Datapath of the Salsa20 core: configuration registers, byte counter, work words,
// quarter-round step unit and output byte register. Depends on salsa_pkg.
module salsa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [salsa_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [salsa_pkg::CsrDataWidth-1:0]    csr_wdata,
   input  logic [7:0]                            req_data_in,
   output logic [7:0]                            rsp_data_out,
   input  salsa_pkg::cmd_type                    cmd,
   output salsa_pkg::sts_type                    sts
);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_ff;
   logic        mode_ff;
   logic [63:0] count_ff, count_in;
   salsa_pkg::block_type w_ff, w_in;
   salsa_pkg::block_type init_ff, init_in;
   salsa_pkg::block_type init_word;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [57:0] block_index;
   logic [63:0] hi_a, hi_b;
   logic [3:0] tgt_idx [4];
   logic [3:0] src_a_idx [4];
   logic [3:0] src_b_idx [4];
   salsa_pkg::word_type ks_word;
   logic [7:0] ks_byte;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         nonce_ff  <= '0;
         mode_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            salsa_pkg::CsrKeyWord0: key_ff[0] <= csr_wdata;
            salsa_pkg::CsrKeyWord1: key_ff[1] <= csr_wdata;
            salsa_pkg::CsrKeyWord2: key_ff[2] <= csr_wdata;
            salsa_pkg::CsrKeyWord3: key_ff[3] <= csr_wdata;
            salsa_pkg::CsrNonce:    nonce_ff  <= csr_wdata;
            salsa_pkg::CsrKeyMode:  mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Initial block from constants, key, nonce and block index
   assign block_index = count_ff[63:6];
   assign hi_a = mode_ff ? key_ff[2] : key_ff[0];
   assign hi_b = mode_ff ? key_ff[3] : key_ff[1];

   always_comb begin
      init_word[0]  = salsa_pkg::ExpandWord0;
      init_word[1]  = key_ff[0][31:0];
      init_word[2]  = key_ff[0][63:32];
      init_word[3]  = key_ff[1][31:0];
      init_word[4]  = key_ff[1][63:32];
      init_word[5]  = mode_ff ? salsa_pkg::Sigma5 : salsa_pkg::Tau5;
      init_word[6]  = nonce_ff[31:0];
      init_word[7]  = nonce_ff[63:32];
      init_word[8]  = block_index[31:0];
      init_word[9]  = {6'b000000, block_index[57:32]};
      init_word[10] = mode_ff ? salsa_pkg::Sigma10 : salsa_pkg::Tau10;
      init_word[11] = hi_a[31:0];
      init_word[12] = hi_a[63:32];
      init_word[13] = hi_b[31:0];
      init_word[14] = hi_b[63:32];
      init_word[15] = salsa_pkg::ExpandWord15;
   end

   // Word indexes of the current quarter-round line for each quarter
   always_comb begin
      for (int q = 0; q < 4; q++) begin
         tgt_idx[q]   = salsa_pkg::word_index(cmd.row, 2'(q), cmd.qstep + 2'd1);
         src_a_idx[q] = salsa_pkg::word_index(cmd.row, 2'(q), cmd.qstep);
         src_b_idx[q] = salsa_pkg::word_index(cmd.row, 2'(q), cmd.qstep + 2'd3);
      end
   end

   always_comb begin
      w_in    = w_ff;
      init_in = init_ff;
      if (cmd.load) begin
         w_in    = init_word;
         init_in = init_word;
      end else if (cmd.step) begin
         // quarters touch disjoint words, so all four update from w_ff
         for (int q = 0; q < 4; q++) begin
            w_in[tgt_idx[q]] = w_ff[tgt_idx[q]] ^
               salsa_pkg::rotate_step(w_ff[src_a_idx[q]] + w_ff[src_b_idx[q]], cmd.qstep);
         end
      end else if (cmd.finish) begin
         for (int i = 0; i < salsa_pkg::WordCount; i++) begin
            w_in[i] = w_ff[i] + init_ff[i];
         end
      end
   end

   // Keystream byte k is byte k mod 4 of word k / 4
   assign ks_word = w_ff[count_ff[5:2]];
   assign ks_byte = ks_word[{count_ff[1:0], 3'b000} +: 8];

   always_comb begin
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.take) begin
         count_in    = count_ff + 64'd1;
         rsp_data_in = req_data_in ^ ks_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      init_ff     <= init_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.pos_zero = (count_ff[5:0] == 6'd0);
   assign rsp_data_out = rsp_data_ff;

endmodule

### rtl/core/salsa20_stream_cipher_core.sv
// Top level of the Salsa20/20 byte stream cipher: XORs each request byte with keystream.
// Depends on salsa_pkg, salsa_ctrl and salsa_dp.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    req_data_in[7:0]
//  rsp       out        rsp_valid/rsp_ready    rsp_data_out[7:0]
//  csr       in         csr_wr_en (no wait)    csr_index[2:0], csr_wdata[63:0]
//
// A byte inside a block needs no new block; its result is registered and shows the next cycle.
// Every 64th byte first waits for a new block: a load, 8 steps per double round (80 for
// 20 rounds) on the shared quarter-round step unit, then the final add.
// No request is taken during generation; inside a block bytes stream while responses drain.
// Reset clears the byte count, key, nonce and handshake and sets mode to 32-byte keys;
// the first request always triggers block generation. A stalled response holds; a new
// request is still taken in the cycle the waiting response leaves.
module salsa20_stream_cipher_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_data_out,
   input  logic                               csr_wr_en,
   input  logic [salsa_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [salsa_pkg::CsrDataWidth-1:0] csr_wdata
);

   // Command and status between the sequencer and the datapath
   salsa_pkg::cmd_type cmd;
   salsa_pkg::sts_type sts;

   // Sequence block generation and gate the request/response handshake
   salsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold configuration, the byte count and the keystream block; form the result byte
   salsa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data_in  (req_data_in),
      .rsp_data_out (rsp_data_out),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule
